// File: hw/rtl/fzcp_pkg.sv
`timescale 1ns / 1ps

package fzcp_pkg;

  // Field widths
  localparam int HOP_W        = 13;
  localparam int FRAME_SIZE_W = 15;
  localparam int RATE_W       = 18;
  localparam int CHAN_W       = 2;
  localparam int POS_W        = 32;
  localparam int FNUM_W       = 32;
  localparam int CROSS_W      = 14;
  localparam int LEN_W        = 15;
  localparam int PITCH_W      = 21;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 18;

  // Parameter defaults
  localparam int DEF_MAX_OPEN    = 8;
  localparam int DEF_MAX_FRAME   = 16384;
  localparam int DEF_SAMPLE_BITS = 24;

  // Register reset values and defaults
  localparam int DEFAULT_HOP        = 512;
  localparam int DEFAULT_FRAME_HOPS = 4;
  localparam int RESET_FRAME_SIZE   = 0;
  localparam int RESET_RATE         = 48000;
  localparam int RESET_CHANNELS     = 1;

  // Pitch = crossings * rate * 8 / length, so Q4 over the factor of two
  localparam int PITCH_SH = 3;
  localparam int PROD_W   = POS_W + RATE_W;
  localparam int DIVD_W   = PROD_W + PITCH_SH;

  // Iteration counter for the serial remainder and quotient units
  localparam int STEP_W = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HOP_SIZE   = 2'd0,
    REG_FRAME_SIZE = 2'd1,
    REG_RATE       = 2'd2,
    REG_CHANNELS   = 2'd3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOD,
    ST_OPEN,
    ST_CHECK,
    ST_MUL,
    ST_DIV_INIT,
    ST_DIV,
    ST_EMIT,
    ST_FINISH
  } ctrl_state_t;

  typedef struct packed {
    logic take;      // ready for an input item
    logic mod_step;  // one bit of position modulo hop
    logic open;      // open a frame if on a hop boundary
    logic mul;       // multiply crossings by rate for the head frame
    logic div_init;  // set up the quotient unit
    logic div_step;  // one quotient bit
    logic emit;      // load the result register and drop the head frame
    logic finish;    // advance position or clear the clip
  } dp_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic mod_last;
    logic close_head;
    logic div_last;
    logic out_free;
  } dp_status_t;

endpackage

// File: hw/rtl/fzcp_audio_if.sv
`timescale 1ns / 1ps

interface fzcp_audio_if #(
  parameter int SAMPLE_BITS = fzcp_pkg::DEF_SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_first;
  logic signed [SAMPLE_BITS-1:0] sample_second;
  logic                          end_of_clip;

  modport source (output valid, sample_first, sample_second, end_of_clip, input ready);
  modport sink   (input valid, sample_first, sample_second, end_of_clip, output ready);
endinterface

// File: hw/rtl/fzcp_result_if.sv
`timescale 1ns / 1ps

interface fzcp_result_if;
  logic                           valid;
  logic                           ready;
  logic [fzcp_pkg::FNUM_W-1:0]    frame_number;
  logic [fzcp_pkg::CROSS_W-1:0]   crossing_count;
  logic [fzcp_pkg::LEN_W-1:0]     frame_length;
  logic [fzcp_pkg::PITCH_W-1:0]   pitch_q4;
  logic                           last_frame;

  modport source (output valid, frame_number, crossing_count, frame_length, pitch_q4,
                  last_frame, input ready);
  modport sink   (input valid, frame_number, crossing_count, frame_length, pitch_q4,
                  last_frame, output ready);
endinterface

// File: hw/rtl/fzcp_cfg_if.sv
`timescale 1ns / 1ps

interface fzcp_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [fzcp_pkg::CFG_IDX_W-1:0]  reg_index;
  logic [fzcp_pkg::CFG_DATA_W-1:0] write_data;

  modport source (output valid, reg_index, write_data, input ready);
  modport sink   (input valid, reg_index, write_data, output ready);
endinterface

// File: hw/rtl/fzcp_ctrl.sv
`timescale 1ns / 1ps

module fzcp_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  fzcp_pkg::dp_status_t status,
  output fzcp_pkg::dp_cmd_t    cmd
);
  import fzcp_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (status.in_valid) state_next = ST_MOD;
      end
      ST_MOD: begin
        if (status.mod_last) state_next = ST_OPEN;
      end
      ST_OPEN:     state_next = ST_CHECK;
      ST_CHECK: begin
        state_next = status.close_head ? ST_MUL : ST_FINISH;
      end
      ST_MUL:      state_next = ST_DIV_INIT;
      ST_DIV_INIT: state_next = ST_DIV;
      ST_DIV: begin
        if (status.div_last) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) state_next = ST_CHECK;
      end
      ST_FINISH:   state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE:     cmd.take     = 1'b1;
      ST_MOD:      cmd.mod_step = 1'b1;
      ST_OPEN:     cmd.open     = 1'b1;
      ST_CHECK:    cmd          = '0;
      ST_MUL:      cmd.mul      = 1'b1;
      ST_DIV_INIT: cmd.div_init = 1'b1;
      ST_DIV:      cmd.div_step = 1'b1;
      ST_EMIT:     cmd.emit     = status.out_free;
      ST_FINISH:   cmd.finish   = 1'b1;
      default:     cmd          = '0;
    endcase
  end

endmodule

// File: hw/rtl/fzcp_dp.sv
`timescale 1ns / 1ps

module fzcp_dp #(
  parameter int MAX_OPEN    = fzcp_pkg::DEF_MAX_OPEN,
  parameter int MAX_FRAME   = fzcp_pkg::DEF_MAX_FRAME,
  parameter int SAMPLE_BITS = fzcp_pkg::DEF_SAMPLE_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  fzcp_audio_if.sink           audio,
  fzcp_result_if.source        result,
  fzcp_cfg_if.sink             cfg,
  input  fzcp_pkg::dp_cmd_t    cmd,
  output fzcp_pkg::dp_status_t status
);
  import fzcp_pkg::*;

  localparam int PTR_W   = (MAX_OPEN > 1) ? $clog2(MAX_OPEN) : 1;
  localparam int CNT_W   = $clog2(MAX_OPEN + 1);
  localparam int CAP_W   = HOP_W + $clog2(MAX_OPEN + 1);
  localparam int FRAME_W = $clog2(MAX_FRAME + 1);
  localparam int MIX_W   = SAMPLE_BITS + 1;

  // Configuration registers
  logic [HOP_W-1:0]        hop_size;
  logic [FRAME_SIZE_W-1:0] frame_size;
  logic [RATE_W-1:0]       sample_rate_hz;
  logic [CHAN_W-1:0]       channel_count;

  // Clip state
  logic [POS_W-1:0]  sample_position;
  logic              previous_negative;
  logic [POS_W-1:0]  crossing_total;
  logic [FNUM_W-1:0] next_frame_number;
  logic [PTR_W-1:0]  head;
  logic [CNT_W-1:0]  open_count;
  logic              eoc;

  // Open frame store, read only at the head
  logic [POS_W-1:0] open_frame_start    [MAX_OPEN];
  logic [POS_W-1:0] open_frame_snapshot [MAX_OPEN];

  // Serial units
  logic [STEP_W-1:0]  step_cnt;
  logic [HOP_W-1:0]   mod_rem;
  logic [POS_W-1:0]   mod_shift;
  logic [PROD_W-1:0]  prod;
  logic [POS_W-1:0]   len_r;
  logic [POS_W-1:0]   cross_r;
  logic [FNUM_W-1:0]  fnum_r;
  logic               last_r;
  logic [POS_W-1:0]   div_rem;
  logic [PITCH_W-1:0] div_low;
  logic [PITCH_W-1:0] div_q;
  logic               div_sat;
  logic               div_zero;

  // Output register
  logic               out_valid;
  logic [FNUM_W-1:0]  out_fnum;
  logic [CROSS_W-1:0] out_cross;
  logic [LEN_W-1:0]   out_len;
  logic [PITCH_W-1:0] out_pitch;
  logic               out_last;

  // Effective hop and frame size
  logic [HOP_W-1:0]        hop_eff;
  logic [FRAME_SIZE_W-1:0] frame_raw;
  logic [CAP_W-1:0]        open_cap;
  logic [CAP_W-1:0]        frame_capped;
  logic [FRAME_W-1:0]      frame_eff;

  always_comb begin
    hop_eff      = (hop_size != '0) ? hop_size : HOP_W'(DEFAULT_HOP);
    frame_raw    = (frame_size != '0) ? frame_size
                                      : FRAME_SIZE_W'(hop_eff * DEFAULT_FRAME_HOPS);
    open_cap     = CAP_W'(hop_eff) * CAP_W'(MAX_OPEN);
    frame_capped = (CAP_W'(frame_raw) > open_cap) ? open_cap : CAP_W'(frame_raw);
    frame_eff    = (POS_W'(frame_capped) > POS_W'(MAX_FRAME)) ? FRAME_W'(MAX_FRAME)
                                                              : FRAME_W'(frame_capped);
  end

  // Mixed sign of the incoming item
  logic signed [MIX_W-1:0] mix;
  logic                    neg;
  logic                    accept;

  assign accept = audio.valid && cmd.take;
  always_comb begin
    mix = MIX_W'(audio.sample_first);
    if (channel_count[1]) mix = mix + MIX_W'(audio.sample_second);
    neg = mix[MIX_W-1];
  end

  // Store pointers and head frame values
  logic [CNT_W:0]    wr_sum;
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  head_inc;
  logic [POS_W-1:0]  head_len;
  logic [POS_W-1:0]  head_cross;

  always_comb begin
    wr_sum     = (CNT_W + 1)'(head) + (CNT_W + 1)'(open_count);
    wr_ptr     = (wr_sum >= (CNT_W + 1)'(MAX_OPEN)) ? PTR_W'(wr_sum - (CNT_W + 1)'(MAX_OPEN))
                                                    : PTR_W'(wr_sum);
    head_inc   = (head == PTR_W'(MAX_OPEN - 1)) ? '0 : head + 1'b1;
    head_len   = sample_position - open_frame_start[head] + 1'b1;
    head_cross = crossing_total - open_frame_snapshot[head];
  end

  // Serial step arithmetic
  logic [HOP_W:0]        mod_try;
  logic [POS_W:0]        div_try;
  logic [DIVD_W-1:0]     dividend;

  always_comb begin
    mod_try  = {mod_rem, mod_shift[POS_W-1]};
    div_try  = {div_rem, div_low[PITCH_W-1]};
    dividend = {prod, PITCH_SH'(0)};
  end

  assign status.in_valid   = audio.valid;
  assign status.mod_last   = (step_cnt == '0);
  assign status.div_last   = (step_cnt == '0);
  assign status.out_free   = !out_valid || result.ready;
  assign status.close_head = (open_count != '0) &&
                             (eoc || (head_len >= POS_W'(frame_eff)));

  // Configuration port
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hop_size       <= HOP_W'(DEFAULT_HOP);
      frame_size     <= FRAME_SIZE_W'(RESET_FRAME_SIZE);
      sample_rate_hz <= RATE_W'(RESET_RATE);
      channel_count  <= CHAN_W'(RESET_CHANNELS);
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.reg_index))
        REG_HOP_SIZE:   hop_size       <= cfg.write_data[HOP_W-1:0];
        REG_FRAME_SIZE: frame_size     <= cfg.write_data[FRAME_SIZE_W-1:0];
        REG_RATE:       sample_rate_hz <= cfg.write_data[RATE_W-1:0];
        REG_CHANNELS:   channel_count  <= cfg.write_data[CHAN_W-1:0];
        default:        hop_size       <= hop_size;
      endcase
    end
  end

  // Clip state
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_position   <= '0;
      previous_negative <= 1'b0;
      crossing_total    <= '0;
      next_frame_number <= '0;
      head              <= '0;
      open_count        <= '0;
    end else begin
      if (accept) begin
        if (sample_position != '0 && neg != previous_negative) begin
          crossing_total <= crossing_total + 1'b1;
        end
        previous_negative <= neg;
      end
      if (cmd.open && mod_rem == '0 && open_count < CNT_W'(MAX_OPEN)) begin
        open_count        <= open_count + 1'b1;
        next_frame_number <= next_frame_number + 1'b1;
      end
      if (cmd.emit) begin
        head       <= head_inc;
        open_count <= open_count - 1'b1;
      end
      if (cmd.finish) begin
        if (eoc) begin
          sample_position   <= '0;
          previous_negative <= 1'b0;
          crossing_total    <= '0;
          next_frame_number <= '0;
          head              <= '0;
          open_count        <= '0;
        end else begin
          sample_position <= sample_position + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.open && mod_rem == '0 && open_count < CNT_W'(MAX_OPEN)) begin
      open_frame_start[wr_ptr]    <= sample_position;
      open_frame_snapshot[wr_ptr] <= crossing_total;
    end
  end

  // Serial remainder, quotient and multiplier
  always_ff @(posedge clk) begin
    if (accept) begin
      eoc       <= audio.end_of_clip;
      mod_rem   <= '0;
      mod_shift <= sample_position;
      step_cnt  <= STEP_W'(POS_W - 1);
    end
    if (cmd.mod_step) begin
      mod_rem   <= (mod_try >= {1'b0, hop_eff}) ? HOP_W'(mod_try - {1'b0, hop_eff})
                                                : HOP_W'(mod_try);
      mod_shift <= {mod_shift[POS_W-2:0], 1'b0};
      step_cnt  <= step_cnt - 1'b1;
    end
    if (cmd.mul) begin
      prod    <= PROD_W'(head_cross) * PROD_W'(sample_rate_hz);
      len_r   <= head_len;
      cross_r <= head_cross;
      fnum_r  <= next_frame_number - FNUM_W'(open_count);
      last_r  <= eoc && (open_count == CNT_W'(1));
    end
    if (cmd.div_init) begin
      div_rem  <= dividend[DIVD_W-1:PITCH_W];
      div_low  <= dividend[PITCH_W-1:0];
      div_q    <= '0;
      div_zero <= (len_r == '0);
      div_sat  <= (dividend[DIVD_W-1:PITCH_W] >= len_r);
      step_cnt <= STEP_W'(PITCH_W - 1);
    end
    if (cmd.div_step) begin
      div_rem  <= (div_try >= {1'b0, len_r}) ? POS_W'(div_try - {1'b0, len_r})
                                             : POS_W'(div_try);
      div_q    <= {div_q[PITCH_W-2:0], (div_try >= {1'b0, len_r})};
      div_low  <= {div_low[PITCH_W-2:0], 1'b0};
      step_cnt <= step_cnt - 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_fnum  <= fnum_r;
      out_cross <= (|cross_r[POS_W-1:CROSS_W]) ? '1 : cross_r[CROSS_W-1:0];
      out_len   <= (|len_r[POS_W-1:LEN_W]) ? '1 : len_r[LEN_W-1:0];
      out_pitch <= div_zero ? '0 : (div_sat ? '1 : div_q);
      out_last  <= last_r;
    end
  end

  assign audio.ready           = cmd.take;
  assign result.valid          = out_valid;
  assign result.frame_number   = out_fnum;
  assign result.crossing_count = out_cross;
  assign result.frame_length   = out_len;
  assign result.pitch_q4       = out_pitch;
  assign result.last_frame     = out_last;

endmodule

// File: hw/rtl/framed_zero_crossing_pitch.sv
`timescale 1ns / 1ps

// Framed zero-crossing pitch estimator.
// audio: one item per sample (sample_first, sample_second, end_of_clip). With
//   channel_count bit 1 set the two samples are summed; only the mix sign counts.
// pitch: one item per finished frame, oldest first, with frame number, crossing
//   count, frame length, pitch in Hz (Q4, floor) and last_frame on the final
//   result of an end-of-clip item.
// cfg: register writes (hop_size, frame_size, sample_rate_hz, channel_count);
//   always ready. Write only while no item is in flight.
// Sequence: one item at a time. An item with no result passes through accept,
//   the bit-serial position-modulo-hop unit, frame open, close check and
//   finish. Each frame that closes adds multiply, setup, the bit-serial
//   quotient unit, the result load and the next close check.
// A result sits in an output register while the next result is computed; if
//   the receiver stalls, the block holds in the result load until the register
//   frees, and the audio side stays not ready.
// Reset: registers return to hop 512, frame size 0 (four hops), 48000 Hz, one
//   channel; clip state and the result valid flag clear. The open frame store
//   needs no clearing pass; only written entries are read.
module framed_zero_crossing_pitch #(
  parameter int MAX_OPEN    = fzcp_pkg::DEF_MAX_OPEN,
  parameter int MAX_FRAME   = fzcp_pkg::DEF_MAX_FRAME,
  parameter int SAMPLE_BITS = fzcp_pkg::DEF_SAMPLE_BITS
) (
  input  logic          clk,
  input  logic          rst,
  fzcp_audio_if.sink    audio,
  fzcp_result_if.source pitch,
  fzcp_cfg_if.sink      cfg
);
  import fzcp_pkg::*;

  // Controller drives the datapath through one command word and reads status.
  dp_cmd_t    cmd;
  dp_status_t status;

  fzcp_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  // Datapath holds the registers, clip state, frame store and serial units.
  fzcp_dp #(
    .MAX_OPEN    (MAX_OPEN),
    .MAX_FRAME   (MAX_FRAME),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .audio  (audio),
    .result (pitch),
    .cfg    (cfg),
    .cmd    (cmd),
    .status (status)
  );

endmodule
